>>> hw/rtl/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = 13;
    localparam int MAX_SAMPLES = 4096;
    localparam int SUM_W       = 28;
    localparam int SQ_W        = 43;
    localparam int XY_W        = 44;
    localparam int TAG_W       = 8;
    localparam int MUL_W       = 64;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int WIDE_W      = 144;
    localparam int Q_W         = 16;
    localparam int Q_BIT_W     = 4;
    localparam int CFG_W       = 32;
    localparam int IDX_W       = 1;
    localparam int MAG_W       = 58;

    typedef logic [IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_MIN_COUNT = 1'b0;
    localparam cfg_idx_t REG_DEN_MIN   = 1'b1;

    localparam logic [Q_W-1:0] Q_ONE = 16'h8000;
    localparam logic [Q_W-1:0] Q_MAX = 16'h7FFF;

    typedef struct packed {
        logic        [CNT_W-1:0] cnt;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [XY_W-1:0]  sxy;
        logic        [SQ_W-1:0]  sxx;
        logic        [SQ_W-1:0]  syy;
        logic        [TAG_W-1:0] tag_a;
        logic        [TAG_W-1:0] tag_b;
    } snap_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    typedef enum logic [2:0] {
        OP_NXX,
        OP_SXX,
        OP_NYY,
        OP_SYY,
        OP_VXY,
        OP_NXY,
        OP_SXY,
        OP_MAG
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_START,
        S_MUL_WAIT,
        S_SEARCH_A,
        S_SEARCH_B,
        S_DONE
    } back_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/ppc_front.sv
`default_nettype none
module ppc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [ppc_pkg::SAMPLE_W-1:0] x,
    input  wire logic signed [ppc_pkg::SAMPLE_W-1:0] y,
    input  wire logic                             x_missing,
    input  wire logic                             y_missing,
    input  wire logic                             last,
    input  wire logic [ppc_pkg::TAG_W-1:0]        row_a,
    input  wire logic [ppc_pkg::TAG_W-1:0]        row_b,
    input  wire logic                             full,
    output logic                                  push,
    output ppc_pkg::snap_t                        push_data
);
    import ppc_pkg::*;

    logic        [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic signed [XY_W-1:0]       sxy_reg, sxy_next;
    logic        [SQ_W-1:0]       sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [2*SAMPLE_W-1:0] pxy, pxx, pyy;
    logic                         accept, use_pair;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign use_pair = !x_missing && !y_missing && (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign pxy = x * y;
    assign pxx = x * x;
    assign pyy = y * y;

    always_comb
    begin
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxy_next = sxy_reg;
        sxx_next = sxx_reg;
        syy_next = syy_reg;
        if (use_pair)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            sx_next  = sx_reg + SUM_W'(x);
            sy_next  = sy_reg + SUM_W'(y);
            sxy_next = sxy_reg + XY_W'(pxy);
            sxx_next = sxx_reg + SQ_W'($unsigned(pxx));
            syy_next = syy_reg + SQ_W'($unsigned(pyy));
        end
    end

    assign push = accept && last;

    always_comb
    begin
        push_data.cnt   = cnt_next;
        push_data.sx    = sx_next;
        push_data.sy    = sy_next;
        push_data.sxy   = sxy_next;
        push_data.sxx   = sxx_next;
        push_data.syy   = syy_next;
        push_data.tag_a = row_a;
        push_data.tag_b = row_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                cnt_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxy_reg <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sx_reg  <= sx_next;
                sy_reg  <= sy_next;
                sxy_reg <= sxy_next;
                sxx_reg <= sxx_next;
                syy_reg <= syy_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ppc_fifo.sv
`default_nettype none
module ppc_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ppc_pkg::snap_t push_data,
    input  wire logic           pop,
    output ppc_pkg::snap_t      head,
    output logic                full,
    output logic                empty
);
    import ppc_pkg::*;

    snap_t      mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ppc_mul.sv
`default_nettype none
module ppc_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ppc_pkg::MUL_W-1:0]   a,
    input  wire logic [ppc_pkg::MUL_W-1:0]   b,
    output ppc_pkg::mul_stat_t               stat,
    output logic [ppc_pkg::PROD_W-1:0]       p
);
    import ppc_pkg::*;

    logic [PROD_W-1:0] acc_reg, a_sh_reg;
    logic [MUL_W-1:0]  b_sh_reg;
    logic              busy_reg, done_reg;

    assign p         = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= PROD_W'(a);
            b_sh_reg <= b;
        end
        else if (busy_reg && (b_sh_reg != '0))
        begin
            if (b_sh_reg[0])
            begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && (b_sh_reg == '0))
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ppc_back.sv
`default_nettype none
module ppc_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ppc_pkg::CNT_W-1:0]      min_count,
    input  wire logic [ppc_pkg::CFG_W-1:0]      den_min,
    input  wire logic                           empty,
    input  wire ppc_pkg::snap_t                 head,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [ppc_pkg::Q_W-1:0]      correlation,
    output logic                                defined,
    output logic [ppc_pkg::TAG_W-1:0]           tag_a,
    output logic [ppc_pkg::TAG_W-1:0]           tag_b,
    output logic [ppc_pkg::CNT_W-1:0]           used_count
);
    import ppc_pkg::*;

    back_state_t         state_reg, state_next;
    op_t                 op_reg;
    snap_t               s_reg;
    logic [2*CFG_W-1:0]  den2_reg;
    logic [MUL_W-1:0]    t1_reg, vx_reg, vy_reg, mag_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg, def_reg;
    logic [WIDE_W-1:0]   rhs_reg, p2_reg, w_reg, ps_reg, cand_reg, w_upd;
    logic [Q_BIT_W-1:0]  bit_idx_reg;
    logic [Q_W-1:0]      q_reg, qc;
    logic                out_valid_reg, def_out_reg;
    logic [Q_W-1:0]      corr_reg, corr_val;
    logic [TAG_W-1:0]    tag_a_reg, tag_b_reg;
    logic [CNT_W-1:0]    cnt_out_reg;

    logic                mul_start;
    logic [MUL_W-1:0]    mul_a, mul_b;
    mul_stat_t           mul_stat;
    logic [PROD_W-1:0]   mul_p;
    logic                def_ok, out_free, take;
    logic [SUM_W-1:0]    abs_sx, abs_sy;
    logic [XY_W-1:0]     abs_sxy;
    logic                sxy_neg, b_neg;
    logic [MAG_W-1:0]    pos_sum, nga_sum;

    ppc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .p     (mul_p)
    );

    assign abs_sx  = s_reg.sx[SUM_W-1] ? SUM_W'(-s_reg.sx) : SUM_W'(s_reg.sx);
    assign abs_sy  = s_reg.sy[SUM_W-1] ? SUM_W'(-s_reg.sy) : SUM_W'(s_reg.sy);
    assign abs_sxy = s_reg.sxy[XY_W-1] ? XY_W'(-s_reg.sxy) : XY_W'(s_reg.sxy);
    assign sxy_neg = s_reg.sxy[XY_W-1];
    assign b_neg   = s_reg.sx[SUM_W-1] != s_reg.sy[SUM_W-1];
    assign pos_sum = (sxy_neg ? MAG_W'(0) : MAG_W'(t1_reg))
                   + (b_neg ? MAG_W'(mul_p) : MAG_W'(0));
    assign nga_sum = (sxy_neg ? MAG_W'(t1_reg) : MAG_W'(0))
                   + (b_neg ? MAG_W'(0) : MAG_W'(mul_p));

    assign def_ok   = (s_reg.cnt >= min_count) && (mul_p != '0)
                   && (mul_p >= PROD_W'(den2_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign take     = cand_reg <= rhs_reg;
    assign w_upd    = take ? (w_reg + (ps_reg << 1)) : w_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            OP_NXX: begin mul_a = MUL_W'(s_reg.cnt); mul_b = MUL_W'(s_reg.sxx); end
            OP_SXX: begin mul_a = MUL_W'(abs_sx);    mul_b = MUL_W'(abs_sx);    end
            OP_NYY: begin mul_a = MUL_W'(s_reg.cnt); mul_b = MUL_W'(s_reg.syy); end
            OP_SYY: begin mul_a = MUL_W'(abs_sy);    mul_b = MUL_W'(abs_sy);    end
            OP_VXY: begin mul_a = vx_reg;            mul_b = vy_reg;            end
            OP_NXY: begin mul_a = MUL_W'(s_reg.cnt); mul_b = MUL_W'(abs_sxy);   end
            OP_SXY: begin mul_a = MUL_W'(abs_sx);    mul_b = MUL_W'(abs_sy);    end
            OP_MAG: begin mul_a = mag_reg;           mul_b = mag_reg;           end
            default: begin mul_a = '0;               mul_b = '0;                end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    state_next = S_MUL_START;
                end
            end
            S_MUL_START:
            begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mul_stat.done)
                begin
                    if ((op_reg == OP_VXY) && !def_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else if (op_reg == OP_MAG)
                    begin
                        state_next = S_SEARCH_A;
                    end
                    else
                    begin
                        state_next = S_MUL_START;
                    end
                end
            end
            S_SEARCH_A:
            begin
                state_next = S_SEARCH_B;
            end
            S_SEARCH_B:
            begin
                if (bit_idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SEARCH_A;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mul_start = 1'b0;
        unique case (state_reg)
            S_IDLE:      pop = !empty;
            S_MUL_START: mul_start = 1'b1;
            default:
            begin
                pop       = 1'b0;
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        qc = (q_reg > Q_ONE) ? Q_ONE : q_reg;
        if (!def_reg)
        begin
            corr_val = '0;
        end
        else if (neg_reg)
        begin
            corr_val = Q_W'(-qc);
        end
        else
        begin
            corr_val = (qc > Q_MAX) ? Q_MAX : qc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s_reg    <= head;
            den2_reg <= den_min * den_min;
            op_reg   <= OP_NXX;
            def_reg  <= 1'b1;
        end
        if ((state_reg == S_MUL_WAIT) && mul_stat.done)
        begin
            op_reg <= op_t'(op_reg + 3'd1);
            case (op_reg)
                OP_NXX, OP_NYY, OP_NXY:
                begin
                    t1_reg <= MUL_W'(mul_p);
                end
                OP_SXX:
                begin
                    vx_reg <= (PROD_W'(t1_reg) >= mul_p) ? MUL_W'(PROD_W'(t1_reg) - mul_p) : '0;
                end
                OP_SYY:
                begin
                    vy_reg <= (PROD_W'(t1_reg) >= mul_p) ? MUL_W'(PROD_W'(t1_reg) - mul_p) : '0;
                end
                OP_VXY:
                begin
                    prod_reg <= mul_p;
                    def_reg  <= def_ok;
                end
                OP_SXY:
                begin
                    if (pos_sum >= nga_sum)
                    begin
                        mag_reg <= MUL_W'(pos_sum - nga_sum);
                        neg_reg <= 1'b0;
                    end
                    else
                    begin
                        mag_reg <= MUL_W'(nga_sum - pos_sum);
                        neg_reg <= 1'b1;
                    end
                end
                OP_MAG:
                begin
                    rhs_reg     <= WIDE_W'(mul_p) << 30;
                    ps_reg      <= WIDE_W'(prod_reg) << 30;
                    p2_reg      <= '0;
                    w_reg       <= '0;
                    q_reg       <= '0;
                    bit_idx_reg <= Q_BIT_W'(Q_W - 1);
                end
                default:
                begin
                    t1_reg <= t1_reg;
                end
            endcase
        end
        if (state_reg == S_SEARCH_A)
        begin
            cand_reg <= p2_reg + w_reg + ps_reg;
        end
        if (state_reg == S_SEARCH_B)
        begin
            if (take)
            begin
                p2_reg <= cand_reg;
                q_reg  <= q_reg | (Q_W'(1) << bit_idx_reg);
            end
            w_reg       <= w_upd >> 1;
            ps_reg      <= ps_reg >> 2;
            bit_idx_reg <= bit_idx_reg - Q_BIT_W'(1);
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            corr_reg    <= corr_val;
            def_out_reg <= def_reg;
            tag_a_reg   <= s_reg.tag_a;
            tag_b_reg   <= s_reg.tag_b;
            cnt_out_reg <= s_reg.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign correlation = $signed(corr_reg);
    assign defined     = def_out_reg;
    assign tag_a       = tag_a_reg;
    assign tag_b       = tag_b_reg;
    assign used_count  = cnt_out_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == S_MUL_WAIT))
        else $error("multiplier finished outside wait state");

    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mul_stat.busy)
        else $error("multiplier busy while back end idle");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> out_valid_reg)
        else $error("finished item not presented");

endmodule
`default_nettype wire

>>> hw/rtl/pairwise_pearson_correlation_top.sv
`default_nettype none
// Pearson correlation of two sample rows with pairwise deletion of missing
// samples. The front end accumulates one (x, y) item per cycle unless it is
// stalled; on an item marked last it hands the sums to a two-entry queue and
// starts the next row pair at once. The back end turns each queued set of sums
// into a Q1.15 coefficient with one shared shift-add multiplier (up to eight
// products) and a 16-step square-root quotient search, each bit of which runs
// through a search-A and a search-B state. The front end stalls only while
// both queue entries are waiting.
module pairwise_pearson_correlation_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ppc_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [ppc_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [ppc_pkg::SAMPLE_W-1:0] x,
    input  wire logic signed [ppc_pkg::SAMPLE_W-1:0] y,
    input  wire logic                                x_missing,
    input  wire logic                                y_missing,
    input  wire logic                                last,
    input  wire logic [ppc_pkg::TAG_W-1:0]           row_a,
    input  wire logic [ppc_pkg::TAG_W-1:0]           row_b,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [ppc_pkg::Q_W-1:0]           correlation,
    output logic                                     defined,
    output logic [ppc_pkg::TAG_W-1:0]                tag_a,
    output logic [ppc_pkg::TAG_W-1:0]                tag_b,
    output logic [ppc_pkg::CNT_W-1:0]                used_count
);
    import ppc_pkg::*;

    logic [CNT_W-1:0] min_count_reg;
    logic [CFG_W-1:0] den_min_reg;
    logic             push, pop, full, empty;
    snap_t            push_data, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg <= CNT_W'(3);
            den_min_reg   <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_COUNT: min_count_reg <= cfg_data[CNT_W-1:0];
                REG_DEN_MIN:   den_min_reg   <= cfg_data;
                default:       den_min_reg   <= den_min_reg;
            endcase
        end
    end

    ppc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x         (x),
        .y         (y),
        .x_missing (x_missing),
        .y_missing (y_missing),
        .last      (last),
        .row_a     (row_a),
        .row_b     (row_b),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    ppc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    ppc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_count   (min_count_reg),
        .den_min     (den_min_reg),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .correlation (correlation),
        .defined     (defined),
        .tag_a       (tag_a),
        .tag_b       (tag_b),
        .used_count  (used_count)
    );

endmodule
`default_nettype wire
